@@ design/sitda_pkg.sv @@
// Shared types, constants and conversion step functions for the decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int NUM_DIGITS  = 10;
    localparam int NIBBLE_W    = 4;
    localparam int BCD_W       = NUM_DIGITS * NIBBLE_W;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

    // Shift-and-add-3 steps done in one pipeline stage.
    localparam int STEPS_PER_STAGE = 8;
    localparam int DABBLE_STAGES   = VALUE_W / STEPS_PER_STAGE;
    // Magnitude stage plus the shift-and-add-3 stages.
    localparam int NUM_STAGES      = DABBLE_STAGES + 1;

    localparam logic [CHAR_W-1:0]   CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]   CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0]   CHAR_MINUS = 8'h2D;
    localparam logic [NIBBLE_W-1:0] ADD_LIMIT  = 4'd4;
    localparam logic [NIBBLE_W-1:0] ADD_FIX    = 4'd3;

    typedef logic [NUM_DIGITS-1:0][NIBBLE_W-1:0] bcd_t;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] bin;
        bcd_t               bcd;
    } conv_t;

    // Shift STEPS_PER_STAGE magnitude bits into the BCD digits, MSB first.
    function automatic conv_t dabble_steps(input conv_t s);
        conv_t            r;
        logic [BCD_W-1:0] flat;
        r = s;
        for (int n = 0; n < STEPS_PER_STAGE; n++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (r.bcd[d] > ADD_LIMIT) begin
                    r.bcd[d] = r.bcd[d] + ADD_FIX;
                end
            end
            flat  = r.bcd;
            flat  = {flat[BCD_W-2:0], r.bin[VALUE_W-1]};
            r.bcd = flat;
            r.bin = {r.bin[VALUE_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Index of the most significant nonzero digit; zero when all digits are zero.
    function automatic logic [DIGIT_IDX_W-1:0] top_digit(input bcd_t bcd);
        logic [DIGIT_IDX_W-1:0] idx;
        idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd[d] != '0) begin
                idx = DIGIT_IDX_W'(d);
            end
        end
        return idx;
    endfunction

endpackage

@@ design/sitda_conv.sv @@
// Pipelined magnitude and binary-to-BCD conversion with per-stage valid bits.
`timescale 1ns / 1ps

module sitda_conv (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sitda_pkg::conv_t                     out_data
);

    localparam int LAST = sitda_pkg::NUM_STAGES - 1;

    logic [sitda_pkg::NUM_STAGES-1:0] valid_reg;
    logic [sitda_pkg::NUM_STAGES-1:0] valid_next;
    logic [sitda_pkg::NUM_STAGES-1:0] advance;
    sitda_pkg::conv_t                 stage_reg  [sitda_pkg::NUM_STAGES];
    sitda_pkg::conv_t                 stage_next [sitda_pkg::NUM_STAGES];
    logic [sitda_pkg::VALUE_W-1:0]    raw;
    logic [sitda_pkg::VALUE_W-1:0]    mag;

    assign raw = in_value;
    // Magnitude in unsigned arithmetic, so the most negative value maps to 2^31.
    assign mag = raw[sitda_pkg::VALUE_W-1] ? (sitda_pkg::VALUE_W'(0) - raw) : raw;

    // A stage moves when it is empty or its successor moves.
    always_comb
    begin
        advance[LAST] = !valid_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            advance[i] = !valid_reg[i] || advance[i+1];
        end
    end

    always_comb
    begin
        valid_next[0]     = in_valid;
        stage_next[0].neg = raw[sitda_pkg::VALUE_W-1];
        stage_next[0].bin = mag;
        stage_next[0].bcd = '0;
        for (int i = 1; i < sitda_pkg::NUM_STAGES; i++) begin
            valid_next[i] = valid_reg[i-1];
            stage_next[i] = sitda_pkg::dabble_steps(stage_reg[i-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < sitda_pkg::NUM_STAGES; i++) begin
                if (advance[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sitda_pkg::NUM_STAGES; i++) begin
            if (advance[i]) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign in_ready  = advance[0];
    assign out_valid = valid_reg[LAST];
    assign out_data  = stage_reg[LAST];

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII text converter.
//
// Input channel: in_valid / in_ready with one signed 32-bit value per
// transaction. Output channel: out_valid / out_ready with one character
// per transaction (char_code), is_last high on the final character of
// the run. A run is an optional '-' then the digits with no leading
// zeros; zero gives the single character '0'. A run is 1 to 11 characters.
// A value passes one magnitude stage and four shift-and-add-3 stages,
// eight bits each, then the character serializer registers its run.
// The conversion pipeline takes a value every cycle while in_ready is
// high; the character serializer sends one character per cycle while
// out_ready is high, and a value's run of characters goes out back to
// back with the next value's run when that value is ready.
// When the receiver stalls the current character holds, the pipeline
// fills up to five values behind it, and then in_ready drops.
// Reset clears all valid bits; no character is pending after reset.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [sitda_pkg::VALUE_W-1:0]  value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic        [sitda_pkg::CHAR_W-1:0]   char_code,
    output logic                                  is_last
);

    logic                                 conv_valid;
    logic                                 conv_ready;
    sitda_pkg::conv_t                     conv_data;

    logic                                 busy_reg;
    logic                                 busy_next;
    logic                                 sign_reg;
    logic                                 sign_next;
    logic [sitda_pkg::DIGIT_IDX_W-1:0]    idx_reg;
    logic [sitda_pkg::DIGIT_IDX_W-1:0]    idx_next;
    sitda_pkg::bcd_t                      bcd_reg;
    logic [sitda_pkg::DIGIT_IDX_W-1:0]    load_idx;
    logic                                 out_fire;
    logic                                 load;

    sitda_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_value  (value),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_data  (conv_data)
    );

    assign out_fire   = out_valid && out_ready;
    // Take the next value when idle, or as the last character of the current run leaves.
    assign conv_ready = !busy_reg || (out_fire && is_last);
    assign load       = conv_valid && conv_ready;
    assign load_idx   = sitda_pkg::top_digit(conv_data.bcd);

    always_comb
    begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            sign_next = conv_data.neg;
            idx_next  = load_idx;
        end else if (out_fire) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else if (sign_reg) begin
                sign_next = 1'b0;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            bcd_reg <= conv_data.bcd;
        end
    end

    assign out_valid = busy_reg;
    assign is_last   = !sign_reg && (idx_reg == '0);
    assign char_code = sign_reg ? sitda_pkg::CHAR_MINUS
                                : (sitda_pkg::CHAR_ZERO
                                   | sitda_pkg::CHAR_W'(bcd_reg[idx_reg]));

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == sitda_pkg::CHAR_MINUS ||
                       (char_code >= sitda_pkg::CHAR_ZERO &&
                        char_code <= sitda_pkg::CHAR_NINE)))
        else $error("character outside '-' and '0'..'9'");

    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        (load && conv_data.neg) |=> (out_valid && char_code == sitda_pkg::CHAR_MINUS))
        else $error("negative run does not open with minus");

    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !conv_data.neg && load_idx != '0) |=>
            (char_code != sitda_pkg::CHAR_ZERO))
        else $error("leading zero in multi-digit run");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && is_last && !conv_valid) |=> !out_valid)
        else $error("output still valid after last character with nothing queued");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg < sitda_pkg::DIGIT_IDX_W'(sitda_pkg::NUM_DIGITS)))
        else $error("digit index out of range");

endmodule

@@ tb/signed_int_to_decimal_ascii_tb.sv @@
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

    localparam int unsigned RADIX      = 10;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          RANDOM_BURST = 60;
    localparam int          TIMEOUT_NS   = 400000;

    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] code;
        logic                         last;
    } text_char_t;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_ready;
    logic signed [sitda_pkg::VALUE_W-1:0] value     = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [sitda_pkg::CHAR_W-1:0]         char_code;
    logic                                 is_last;

    logic signed [sitda_pkg::VALUE_W-1:0] pending_values[$];
    text_char_t                           expected_text[$];
    int                                   values_queued   = 0;
    int                                   values_accepted = 0;
    int                                   error_count     = 0;
    int                                   send_gap        = 0;
    int                                   recv_gap        = 0;
    bit                                   sender_idle_on  = 1'b1;
    logic                                 in_accepted     = 1'b0;
    logic                                 recv_hold       = 1'b0;

    signed_int_to_decimal_ascii uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .is_last   (is_last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly back to back, some short gaps, an occasional long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12)
        begin
            return 0;
        end
        else if (roll < 18)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [sitda_pkg::VALUE_W-1:0] random_value();
        logic [sitda_pkg::VALUE_W-1:0] mag;
        int unsigned                   ceiling;
        int                            len;
        case ($urandom_range(0, 3))
            0:
            begin
                mag = $urandom;
            end
            1:
            begin
                // Random digit count up to nine, so runs of every length up to nine digits show up.
                len     = $urandom_range(1, 9);
                ceiling = 1;
                repeat (len) ceiling = ceiling * RADIX;
                mag = $urandom_range(0, ceiling - 1);
                if ($urandom_range(0, 1))
                begin
                    mag = ~mag + 1'b1;
                end
            end
            2:
            begin
                mag = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 20)
                                           : 32'h8000_0000 + $urandom_range(0, 20);
            end
            default:
            begin
                mag = $urandom_range(0, 20);
                if ($urandom_range(0, 1))
                begin
                    mag = ~mag + 1'b1;
                end
            end
        endcase
        return mag;
    endfunction

    // Expected character run of one value: optional minus, then digits.
    task automatic push_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] raw);
        logic [sitda_pkg::VALUE_W-1:0]  mag;
        logic [sitda_pkg::NIBBLE_W-1:0] digits[sitda_pkg::NUM_DIGITS];
        int                             ndig;
        text_char_t                     ch;
        mag  = raw[sitda_pkg::VALUE_W-1] ? ~raw + 1'b1 : raw;
        ndig = 0;
        do
        begin
            digits[ndig] = sitda_pkg::NIBBLE_W'(mag % RADIX);
            mag          = mag / RADIX;
            ndig++;
        end
        while (mag != 0 && ndig < sitda_pkg::NUM_DIGITS);
        if (raw[sitda_pkg::VALUE_W-1])
        begin
            ch.code = sitda_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            expected_text.push_back(ch);
        end
        for (int i = ndig - 1; i >= 0; i--)
        begin
            ch.code = sitda_pkg::CHAR_ZERO + digits[i];
            ch.last = (i == 0);
            expected_text.push_back(ch);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_value(input logic signed [sitda_pkg::VALUE_W-1:0] v);
        pending_values.push_back(v);
        values_queued++;
    endtask

    task automatic wait_drained();
        while (values_accepted != values_queued || expected_text.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(negedge clk)
    begin : driver
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_accepted)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_values.size() > 0)
            begin
                value    <= pending_values.pop_front();
                in_valid <= 1'b1;
                send_gap = sender_idle_on ? pick_gap() : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (!rst_n || recv_hold)
        begin
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap--;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    always @(posedge clk)
    begin : monitor
        text_char_t want;
        if (rst_n)
        begin
            in_accepted <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                push_decimal_text(value);
                values_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%02h", char_code));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (char_code !== want.code)
                    begin
                        report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                                  char_code, want.code));
                    end
                    if (is_last !== want.last)
                    begin
                        report_mismatch($sformatf("is_last %b, expected %b on char 0x%02h",
                                                  is_last, want.last, want.code));
                    end
                end
            end
        end
    end

    // Stall the output long enough for the pipeline to back up into in_ready.
    initial
    begin : hold_off
        wait (values_accepted >= 30);
        @(negedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        recv_hold <= 1'b0;
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_value(32'sd0);
        queue_value(32'sd1);
        queue_value(-32'sd1);
        queue_value(32'sd9);
        queue_value(32'sd10);
        queue_value(-32'sd10);
        queue_value(32'sd99);
        queue_value(32'sd100);
        queue_value(32'sh7FFF_FFFF);
        queue_value(32'sh8000_0000);
        queue_value(32'sh8000_0001);
        queue_value(32'sd1000000000);
        queue_value(-32'sd1000000000);
        queue_value(32'sd999999999);
        queue_value(32'sd1234567890);
        queue_value(-32'sd123456789);
        queue_value(32'sh5555_5555);
        queue_value(32'shAAAA_AAAA);
        // Sender pause: let everything drain before the next burst.
        wait_drained();

        // Back-to-back offers; the hold-off lands in this burst.
        sender_idle_on = 1'b0;
        repeat (RANDOM_BURST) queue_value(random_value());
        wait_drained();

        sender_idle_on = 1'b1;
        repeat (RANDOM_BURST) queue_value(random_value());
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("signed_int_to_decimal_ascii verification clean");
        end
        else
        begin
            $display("signed_int_to_decimal_ascii verification failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("signed_int_to_decimal_ascii verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/sitda_pkg.sv
design/sitda_conv.sv
design/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_tb.sv
